FILE: rtl/core/qts_pkg.sv
// shared types and constants for the quintic trajectory sampler
`default_nettype none
package qts_pkg;
    localparam int POS_W = 32;
    localparam int VEL_W = 48;
    localparam int DUR_W = 16;
    localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;
endpackage
`default_nettype wire

FILE: rtl/core/qts_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module qts_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic                  out_valid,
    output logic      [NUM_W-1:0] quo,
    output logic      [TAG_W-1:0] tag_out
);
    logic [NUM_W-1:0] q_reg   [NUM_W+1];
    logic [DEN_W:0]   r_reg   [NUM_W+1];
    logic [DEN_W-1:0] d_reg   [NUM_W+1];
    logic [TAG_W-1:0] t_reg   [NUM_W+1];
    logic             v_reg   [NUM_W+1];

    always_comb begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        t_reg[0] = tag_in;
        v_reg[0] = in_valid;
    end

    // one stage per quotient bit, msb first
    for (genvar i = 0; i < NUM_W; i++) begin : g_st
        logic [DEN_W:0]   rs;
        logic [NUM_W-1:0] qs;
        logic [DEN_W:0]   rn_next;
        logic [NUM_W-1:0] qn_next;
        always_comb begin
            rs = {r_reg[i][DEN_W-1:0], q_reg[i][NUM_W-1]};
            qs = {q_reg[i][NUM_W-2:0], 1'b0};
            if (rs >= {1'b0, d_reg[i]}) begin
                rn_next = rs - {1'b0, d_reg[i]};
                qn_next = qs | {{(NUM_W-1){1'b0}}, 1'b1};
            end else begin
                rn_next = rs;
                qn_next = qs;
            end
        end
        logic [DEN_W:0]   rn_reg;
        logic [NUM_W-1:0] qn_reg;
        logic [DEN_W-1:0] dn_reg;
        logic [TAG_W-1:0] tn_reg;
        logic             vn_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vn_reg <= 1'b0;
            end else if (en) begin
                vn_reg <= v_reg[i];
            end
            if (en) begin
                rn_reg <= rn_next;
                qn_reg <= qn_next;
                dn_reg <= d_reg[i];
                tn_reg <= t_reg[i];
            end
        end
        always_comb begin
            r_reg[i+1] = rn_reg;
            q_reg[i+1] = qn_reg;
            d_reg[i+1] = dn_reg;
            t_reg[i+1] = tn_reg;
            v_reg[i+1] = vn_reg;
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quo       = q_reg[NUM_W];
    assign tag_out   = t_reg[NUM_W];
endmodule
`default_nettype wire

FILE: rtl/core/quintic_trajectory_sampler_core.sv
// Quintic trajectory sampler: one word per cycle while the receiver keeps up, fully
// pipelined. Words pass in order through the tau divider (TIME_BITS capped at 16),
// the power chain, the polynomial sums, the diff products, the velocity and
// acceleration dividers running side by side, and the output register.
// Throughput stays one word per clock unless the output stalls.
// All pipeline stages advance together while the output register is free or
// being read, so only a held-off receiver stalls the input.
`default_nettype none
module quintic_trajectory_sampler_core #(
    parameter int TIME_BITS     = 16,
    parameter int TAU_FRAC_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // elapsed_ticks[15:0], start_position[47:16], end_position[79:48]
    input  wire logic [79:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // desired_position[31:0], desired_velocity[79:32], desired_acceleration[127:80]
    output logic [127:0]       m_tdata,
    // past_end
    output logic               m_tuser
);
    import qts_pkg::*;
    localparam int F   = TAU_FRAC_BITS;
    localparam int TW  = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int NW  = TW + F;
    localparam int VNW = 96;
    localparam int AW  = 2*TW;

    logic [DUR_W-1:0] dur_reg;
    logic en;
    logic obuf_full_reg;
    assign en = !obuf_full_reg || m_tready;
    assign s_tready = en;

    // duration register
    always_ff @(posedge aclk) begin
        if (!aresetn) dur_reg <= DUR_RESET;
        else if (cfg_wr_en) dur_reg <= cfg_wr_data;
    end

    logic [TW-1:0] e_in, d_in;
    logic signed [31:0] st_in, en_in;
    logic past_in;
    assign e_in   = s_tdata[TW-1:0];
    assign d_in   = dur_reg[TW-1:0];
    assign st_in  = s_tdata[47:16];
    assign en_in  = s_tdata[79:48];
    assign past_in = e_in >= d_in;

    // tag: start, end, duration, past flag
    localparam int TG = 32 + 32 + TW + 1;
    logic [TG-1:0] tg0, tg1;
    logic [NW-1:0] tau_q;
    logic v1;
    logic [NW-1:0] num0;
    assign num0 = {e_in, {F{1'b0}}};
    assign tg0 = {past_in, d_in, en_in, st_in};

    qts_div #(.NUM_W(NW), .DEN_W(TW), .TAG_W(TG)) u_tau (
        .aclk, .aresetn, .en, .in_valid(s_tvalid), .num(num0),
        .den(past_in ? {{(TW-1){1'b0}}, 1'b1} : d_in), .tag_in(tg0),
        .out_valid(v1), .quo(tau_q), .tag_out(tg1)
    );

    // power chain: one multiply per stage after the first
    logic [F-1:0] t1;
    assign t1 = tau_q[F-1:0];
    logic [F-1:0] pt_reg [5];
    logic [F-1:0] pk_reg [5][5];
    logic [TG-1:0] ptg_reg [5];
    logic pv_reg [5];
    logic [2*F-1:0] prod [5];
    always_comb begin
        prod[0] = '0;
        for (int k = 1; k < 5; k++) prod[k] = {{F{1'b0}}, pk_reg[k-1][k-1]} * {{F{1'b0}}, pt_reg[k-1]};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) pv_reg[k] <= 1'b0;
        end else if (en) begin
            pv_reg[0] <= v1;
            for (int k = 1; k < 5; k++) pv_reg[k] <= pv_reg[k-1];
        end
        if (en) begin
            pt_reg[0] <= t1; ptg_reg[0] <= tg1; pk_reg[0][0] <= t1;
            for (int k = 1; k < 5; k++) begin
                pt_reg[k] <= pt_reg[k-1];
                ptg_reg[k] <= ptg_reg[k-1];
                for (int j = 0; j < k; j++) pk_reg[k][j] <= pk_reg[k-1][j];
                pk_reg[k][k] <= prod[k][2*F-1:F];
            end
        end
    end

    // polynomial sums
    logic signed [F+10:0] s_c, sd_c, sdd_c, one_c;
    always_comb begin
        one_c = (F+11)'(1) <<< F;
        s_c   = (F+11)'(10)*$signed({11'b0, pk_reg[4][2]}) - (F+11)'(15)*$signed({11'b0, pk_reg[4][3]})
              + (F+11)'(6)*$signed({11'b0, pk_reg[4][4]});
        if (s_c < 0) s_c = '0;
        if (s_c > one_c) s_c = one_c;
        sd_c  = (F+11)'(30)*$signed({11'b0, pk_reg[4][1]}) - (F+11)'(60)*$signed({11'b0, pk_reg[4][2]})
              + (F+11)'(30)*$signed({11'b0, pk_reg[4][3]});
        sdd_c = (F+11)'(60)*$signed({11'b0, pk_reg[4][0]}) - (F+11)'(180)*$signed({11'b0, pk_reg[4][1]})
              + (F+11)'(120)*$signed({11'b0, pk_reg[4][2]});
    end
    logic signed [F+10:0] s_reg, sd_reg, sdd_reg;
    logic [TG-1:0] stg_reg;
    logic sv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) sv_reg <= 1'b0;
        else if (en) sv_reg <= pv_reg[4];
        if (en) begin
            s_reg <= s_c; sd_reg <= sd_c; sdd_reg <= sdd_c; stg_reg <= ptg_reg[4];
        end
    end

    // magnitudes and products with diff
    logic signed [32:0] diff_c;
    logic [32:0] dmag_c;
    logic [F+10:0] sdm_c, sddm_c;
    always_comb begin
        diff_c = $signed({stg_reg[63], stg_reg[63:32]}) - $signed({stg_reg[31], stg_reg[31:0]});
        dmag_c = diff_c[32] ? -diff_c : diff_c;
        sdm_c  = sd_reg[F+10] ? -sd_reg : sd_reg;
        sddm_c = sdd_reg[F+10] ? -sdd_reg : sdd_reg;
    end
    logic [33+F+10:0] mp_reg, mv_reg, ma_reg;
    logic nd_reg, nv_reg, na_reg, mvld_reg;
    logic [TG-1:0] mtg_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) mvld_reg <= 1'b0;
        else if (en) mvld_reg <= sv_reg;
        if (en) begin
            mp_reg <= (44+F)'(dmag_c) * (44+F)'(s_reg);
            mv_reg <= (44+F)'(dmag_c) * (44+F)'(sdm_c);
            ma_reg <= (44+F)'(dmag_c) * (44+F)'(sddm_c);
            nd_reg <= diff_c[32];
            nv_reg <= diff_c[32] ^ sd_reg[F+10];
            na_reg <= diff_c[32] ^ sdd_reg[F+10];
            mtg_reg <= stg_reg;
        end
    end

    // position and divider numerators
    logic signed [33:0] pos_c;
    logic [31:0] pos_sat;
    logic [VNW-1:0] vnum, anum;
    logic [33+F+10:0] pshift;
    always_comb begin
        pshift = mp_reg >> F;
        pos_c = $signed({{2{mtg_reg[31]}}, mtg_reg[31:0]})
              + (nd_reg ? -$signed({1'b0, pshift[32:0]}) : $signed({1'b0, pshift[32:0]}));
        if (pos_c > 34'sd2147483647) pos_sat = 32'h7fffffff;
        else if (pos_c < -34'sd2147483648) pos_sat = 32'h80000000;
        else pos_sat = pos_c[31:0];
        if (mtg_reg[TG-1]) pos_sat = mtg_reg[63:32];
        vnum = (F >= 16) ? VNW'(mv_reg >> (F-16)) : VNW'(mv_reg) << (16-F);
        anum = VNW'(ma_reg) << (32-F);
    end
    localparam int TG2 = 32 + 3;
    logic [TG2-1:0] dtg;
    logic [AW-1:0] dd;
    logic [TW-1:0] dur1;
    assign dur1 = mtg_reg[TG-2 -: TW];
    assign dd = mtg_reg[TG-1] ? AW'(1) : AW'(dur1) * AW'(dur1);
    assign dtg = {mtg_reg[TG-1], na_reg, nv_reg, pos_sat};

    logic vv, va;
    logic [VNW-1:0] vq, aq;
    logic [TG2-1:0] vtg, atg;
    qts_div #(.NUM_W(VNW), .DEN_W(TW), .TAG_W(TG2)) u_vel (
        .aclk, .aresetn, .en, .in_valid(mvld_reg), .num(vnum),
        .den(mtg_reg[TG-1] ? TW'(1) : dur1), .tag_in(dtg),
        .out_valid(vv), .quo(vq), .tag_out(vtg)
    );
    qts_div #(.NUM_W(VNW), .DEN_W(AW), .TAG_W(TG2)) u_acc (
        .aclk, .aresetn, .en, .in_valid(mvld_reg), .num(anum), .den(dd), .tag_in(dtg),
        .out_valid(va), .quo(aq), .tag_out(atg)
    );

    // saturation to 48 bits
    function automatic logic [VEL_W-1:0] sat48(input logic [VNW-1:0] m, input logic neg);
        logic [VNW-1:0] mx;
        mx = VNW'(48'h7fff_ffff_ffff);
        if (neg) begin
            if (m > mx + VNW'(1)) sat48 = 48'h8000_0000_0000;
            else sat48 = VEL_W'(-m);
        end else begin
            if (m > mx) sat48 = 48'h7fff_ffff_ffff;
            else sat48 = m[VEL_W-1:0];
        end
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) obuf_full_reg <= 1'b0;
        else if (en) obuf_full_reg <= vv;
        if (en) begin
            m_tdata[31:0]   <= vtg[31:0];
            m_tdata[79:32]  <= vtg[34] ? '0 : sat48(vq, vtg[32]);
            m_tdata[127:80] <= vtg[34] ? '0 : sat48(aq, vtg[33]);
            m_tuser         <= vtg[34];
        end
    end
    assign m_tvalid = obuf_full_reg;

    // both dividers carry matching items
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        vv == va && (!vv || atg == vtg))
        else $error("divider valids diverged");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");
    a_past: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[127:32] == '0)
        else $error("past end word not clamped");
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the quintic trajectory sampler core: predicts every sample and checks the stream
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qts_pkg::*;

    localparam int TAU_F     = 24;
    localparam int LATENCY   = 300;
    localparam int HOLD_LEN  = 900;

    // one predicted sample of the trajectory
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [VEL_W-1:0] velocity;
        logic [VEL_W-1:0] acceleration;
        logic             past_end;
    } sample_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [15:0]   cfg_wr_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // elapsed_ticks[15:0], start_position[47:16], end_position[79:48]
    logic [79:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // desired_position[31:0], desired_velocity[79:32], desired_acceleration[127:80]
    logic [127:0]  m_tdata;
    // past_end
    logic          m_tuser;

    logic [DUR_W-1:0] move_dur = DUR_RESET;
    sample_t          pending_samples[$];
    int               mismatches = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               hold_req = 0;
    int               hold_left = 0;

    quintic_trajectory_sampler_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock, 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // signed magnitude to 48-bit field with saturation
    function automatic logic [VEL_W-1:0] clamp48(logic [127:0] mag, bit neg);
        if (neg) begin
            if (mag > 128'h8000_0000_0000) return 48'h8000_0000_0000;
            return -mag[47:0];
        end
        if (mag > 128'h7fff_ffff_ffff) return 48'h7fff_ffff_ffff;
        return mag[47:0];
    endfunction

    // expected sample for one word at the current move duration
    function automatic sample_t predict_sample(logic [15:0] elapsed,
                                               logic [31:0] start_pos,
                                               logic [31:0] end_pos);
        sample_t      r;
        longint       st, en, diff, s, sd, sdd, t, t2, t3, t4, t5, posl;
        logic [127:0] dmag, w, dd;
        st = longint'($signed(start_pos));
        en = longint'($signed(end_pos));
        diff = en - st;
        r = '0;
        // at or past the end, zero duration included
        if (elapsed >= move_dur) begin
            r.position = end_pos;
            r.past_end = 1'b1;
            return r;
        end
        t  = longint'((64'(elapsed) << TAU_F) / 64'(move_dur));
        t2 = (t * t) >>> TAU_F;
        t3 = (t2 * t) >>> TAU_F;
        t4 = (t3 * t) >>> TAU_F;
        t5 = (t4 * t) >>> TAU_F;
        s = 10 * t3 - 15 * t4 + 6 * t5;
        if (s < 0) s = 0;
        if (s > (64'sd1 << TAU_F)) s = 64'sd1 << TAU_F;
        sd  = 30 * t2 - 60 * t3 + 30 * t4;
        sdd = 60 * t - 180 * t2 + 120 * t3;
        dmag = 128'(diff < 0 ? -diff : diff);
        // position
        w = (dmag * 128'(s)) >> TAU_F;
        posl = st + (diff < 0 ? -longint'(w[63:0]) : longint'(w[63:0]));
        if (posl > 64'sd2147483647) posl = 64'sd2147483647;
        if (posl < -64'sd2147483648) posl = -64'sd2147483648;
        r.position = posl[31:0];
        // velocity
        w = (dmag * 128'(sd < 0 ? -sd : sd)) >> (TAU_F - 16);
        w = w / 128'(move_dur);
        r.velocity = clamp48(w, (diff < 0) != (sd < 0));
        // acceleration
        w = (dmag * 128'(sdd < 0 ? -sdd : sdd)) << (32 - TAU_F);
        dd = 128'(move_dur) * 128'(move_dur);
        w = w / dd;
        r.acceleration = clamp48(w, (diff < 0) != (sdd < 0));
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [127:0] got, logic [127:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // send one word, log its expected sample at acceptance, then idle at random
    task automatic send_word(logic [15:0] elapsed, logic [31:0] start_pos,
                             logic [31:0] end_pos);
        s_tdata  <= {end_pos, start_pos, elapsed};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_samples.push_back(predict_sample(elapsed, start_pos, end_pos));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
    endtask

    // duration is only changed with the pipeline empty
    task automatic set_duration(logic [15:0] dur);
        wait_drain();
        repeat (LATENCY) @(posedge aclk);
        cfg_wr_data <= dur;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        move_dur = dur;
    endtask

    // random word: mostly inside the move, sometimes anywhere
    task automatic send_random_word();
        logic [15:0] elapsed;
        logic [31:0] start_pos, end_pos;
        if (move_dur != 0 && $urandom_range(99) < 75)
            elapsed = 16'($urandom_range(move_dur - 1));
        else
            elapsed = 16'($urandom);
        start_pos = $urandom;
        case ($urandom_range(3))
            0: end_pos = start_pos + 32'($signed(16'($urandom)));
            1: end_pos = start_pos;
            default: end_pos = $urandom;
        endcase
        send_word(elapsed, start_pos, end_pos);
    endtask

    task automatic pick_random_duration();
        case ($urandom_range(5))
            0: set_duration(16'd1);
            1: set_duration(16'd65535);
            2: set_duration(16'($urandom_range(2, 64)));
            default: set_duration(16'($urandom_range(1, 65535)));
        endcase
    endtask

    // reset duration: start, middle, end and saturating moves
    task automatic test_default_duration();
        send_word(16'd0, 32'h1000_0000, 32'hf000_0000);
        send_word(16'd500, 32'h0000_0000, 32'h1000_0000);
        send_word(16'd999, 32'h1000_0000, 32'h0000_0000);
        send_word(16'd1000, 32'h1234_5678, 32'h8765_4321);
        send_word(16'd65535, 32'h0000_0000, 32'h7fff_ffff);
        send_word(16'd250, 32'h8000_0000, 32'h7fff_ffff);
        send_word(16'd750, 32'h7fff_ffff, 32'h8000_0000);
        send_word(16'd1, 32'h0000_0001, 32'h0000_0001);
    endtask

    // shortest and longest moves
    task automatic test_duration_extremes();
        set_duration(16'd1);
        send_word(16'd0, 32'h8000_0000, 32'h7fff_ffff);
        send_word(16'd1, 32'h8000_0000, 32'h7fff_ffff);
        set_duration(16'd2);
        send_word(16'd1, 32'h7fff_ffff, 32'h8000_0000);
        send_word(16'd1, 32'h8000_0000, 32'h7fff_ffff);
        set_duration(16'd65535);
        send_word(16'd32768, 32'h8000_0000, 32'h7fff_ffff);
        send_word(16'd65534, 32'h0000_0000, 32'hffff_ffff);
        send_word(16'd65535, 32'hdead_beef, 32'h0bad_f00d);
        send_word(16'd1, 32'h8000_0000, 32'h7fff_ffff);
    endtask

    // zero duration counts every word as past the end
    task automatic test_zero_duration();
        set_duration(16'd0);
        send_word(16'd0, 32'h1111_1111, 32'h2222_2222);
        send_word(16'd65535, 32'h8000_0000, 32'h7fff_ffff);
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pick_random_duration();
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 99) pick_random_duration();
            send_random_word();
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_duration(16'd300);
        hold_req = HOLD_LEN;
        for (int i = 0; i < 300; i++) send_random_word();
        wait_drain();
        for (int i = 0; i < 50; i++) send_random_word();
    endtask

    // receiver ready, with random stalls and a counted hold-off
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each output word with the oldest predicted sample
    always @(posedge aclk) begin : check_samples
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[31:0] !== want.position)
                    report_mismatch("position", m_tdata[31:0], want.position);
                if (m_tdata[79:32] !== want.velocity)
                    report_mismatch("velocity", m_tdata[79:32], want.velocity);
                if (m_tdata[127:80] !== want.acceleration)
                    report_mismatch("acceleration", m_tdata[127:80], want.acceleration);
                if (m_tuser !== want.past_end)
                    report_mismatch("past_end", m_tuser, want.past_end);
            end
        end
    end

    // main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_duration();
        test_duration_extremes();
        test_zero_duration();
        test_random_phase(450, 0, 0);
        test_random_phase(350, 86, 0);
        test_random_phase(350, 0, 86);
        test_random_phase(400, 9, 9);
        test_backpressure();
        wait_drain();
        repeat (LATENCY) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
